// ===== hdl/mssb_pkg.sv =====
// ----------------------------------------------------------------------------
// Mass-spring soft body package
// Shared request and response types, command and register codes, the state
// encoding of the step sequencer and the saturation and wrap helpers.
// ----------------------------------------------------------------------------
package mssb_pkg;

  // Command codes carried in a request.
  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_LOAD   = 3'd0;
  localparam cmd_t CMD_FORCE  = 3'd1;
  localparam cmd_t CMD_SETPOS = 3'd2;
  localparam cmd_t CMD_STEP   = 3'd3;
  localparam cmd_t CMD_READ   = 3'd4;

  // Configuration register indexes.
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_TENSION   = 3'd0;
  localparam reg_idx_t REG_MASS      = 3'd1;
  localparam reg_idx_t REG_COUNT     = 3'd2;
  localparam reg_idx_t REG_WIDTH     = 3'd3;
  localparam reg_idx_t REG_HEIGHT    = 3'd4;

  localparam int CFG_W = 17;

  // Register reset values.
  localparam logic [16:0] TENSION_RST = 17'd6554;
  localparam logic [10:0] MASS_RST    = 11'd10;
  localparam logic [4:0]  COUNT_RST   = 5'd4;
  localparam logic [15:0] WIDTH_RST   = 16'd640;
  localparam logic [15:0] HEIGHT_RST  = 16'd480;

  typedef struct packed {
    cmd_t               command;
    logic [3:0]         cell_index;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic               status;
  } rsp_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_CMD_LD,
    S_P_RD, S_P_LD, S_C_RD, S_C_LD, S_MULY, S_ACC, S_P_WB,
    S_M_RD, S_M_LD, S_DIV_X, S_DIV_Y, S_M_WB,
    S_MEAN_GO, S_MEAN_X, S_MEAN_Y, S_WRAP, S_DONE
  } state_t;

  // Clamp a wide signed value into the 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Wrap a position once at the screen edge given in whole pixels.
  function automatic logic signed [31:0] wrap32(input logic signed [31:0] p,
                                                input logic [15:0] lim);
    logic signed [34:0] x;
    logic signed [34:0] w;
    w = $signed({3'b000, lim, 16'h0000});
    x = 35'(p);
    if (x > w) x = x - w;
    if (x < 35'sd0) x = x + w;
    return sat32(64'(x));
  endfunction

endpackage

// ===== hdl/mssb_div.sv =====
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division of a signed dividend by an unsigned 11-bit divisor, one
// quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module mssb_div #(
  parameter int DW = 37
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic signed [DW-1:0]   dividend,
  input  logic [10:0]            divisor,
  output logic signed [DW-1:0]   quotient,
  output mssb_pkg::div_stat_t    stat
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   mag;
  logic [10:0]     rem;
  logic [10:0]     dsr;
  logic            neg;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            done;
  logic [11:0]     part;
  logic [11:0]     diff;
  logic            ge;

  // Trial subtraction of one step.
  assign part = {rem, mag[DW-1]};
  assign ge   = part >= {1'b0, dsr};
  assign diff = part - {1'b0, dsr};

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (go) begin
      mag <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      neg <= dividend[DW-1];
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[10:0] : part[10:0];
      mag <= {mag[DW-2:0], ge};
    end
  end

  assign quotient = neg ? -$signed(mag) : $signed(mag);
  assign stat     = '{busy: busy, done: done};

endmodule

// ===== hdl/mass_spring_soft_body_step_top.sv =====
// ----------------------------------------------------------------------------
// Mass-spring soft body step
// Cell store, spring and Euler step sequencer around one shared multiplier
// and one serial divider.
// ----------------------------------------------------------------------------
// One request at a time. A step first runs the spring terms one pair at a
// time through the single multiplier, then the moves, whose force/mass
// divisions go one quotient bit per cycle through the shared divider
// (SW = 33 + log2(MAX_CELLS), 37 at the default), then the mean. A
// finished response waits in the output register while the next request
// is taken.
module mass_spring_soft_body_step_top #(
  parameter int MAX_CELLS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mssb_pkg::req_t            in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mssb_pkg::rsp_t            out_data,
  input  logic                      cfg_we,
  input  mssb_pkg::reg_idx_t        cfg_index,
  input  logic [mssb_pkg::CFG_W-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int NW = (CW > 5) ? CW : 5;
  localparam int SW = 33 + IW;

  // Configuration registers.
  logic [16:0] tension;
  logic [10:0] cell_mass;
  logic [4:0]  cell_count;
  logic [15:0] screen_width;
  logic [15:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      tension       <= mssb_pkg::TENSION_RST;
      cell_mass     <= mssb_pkg::MASS_RST;
      cell_count    <= mssb_pkg::COUNT_RST;
      screen_width  <= mssb_pkg::WIDTH_RST;
      screen_height <= mssb_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mssb_pkg::REG_TENSION: tension       <= cfg_data[16:0];
        mssb_pkg::REG_MASS:    cell_mass     <= cfg_data[10:0];
        mssb_pkg::REG_COUNT:   cell_count    <= cfg_data[4:0];
        mssb_pkg::REG_WIDTH:   screen_width  <= cfg_data[15:0];
        mssb_pkg::REG_HEIGHT:  screen_height <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mssb_pkg::state_t state, state_next;
  mssb_pkg::req_t   req;
  mssb_pkg::rsp_t   res;

  // Cells in use and the request's cell address.
  logic [NW-1:0] n_w;
  logic [CW-1:0] n;
  logic [NW-1:0] idx_w;
  logic          in_range;
  logic [IW-1:0] idx_a;
  logic [10:0]   mass_div;

  assign n_w      = (NW'(cell_count) < NW'(MAX_CELLS)) ? NW'(cell_count) : NW'(MAX_CELLS);
  assign n        = CW'(n_w);
  assign idx_w    = NW'(req.cell_index);
  assign in_range = idx_w < n_w;
  assign idx_a    = idx_w[IW-1:0];
  assign mass_div = (cell_mass == 11'd0) ? 11'd1 : cell_mass;

  // Loop counters over parent and child cells.
  logic [CW-1:0] p, c;
  logic [CW-1:0] p_inc, c_inc;
  logic [IW-1:0] pa, ca;
  assign p_inc = p + CW'(1);
  assign c_inc = c + CW'(1);
  assign pa    = p[IW-1:0];
  assign ca    = c[IW-1:0];

  // Cell store.
  logic signed [31:0] off_x_mem [MAX_CELLS];
  logic signed [31:0] off_y_mem [MAX_CELLS];
  logic signed [31:0] st_x_mem  [MAX_CELLS];
  logic signed [31:0] st_y_mem  [MAX_CELLS];
  logic signed [31:0] spd_x_mem [MAX_CELLS];
  logic signed [31:0] spd_y_mem [MAX_CELLS];
  logic signed [31:0] psh_x_mem [MAX_CELLS];
  logic signed [31:0] psh_y_mem [MAX_CELLS];
  logic [MAX_CELLS-1:0] spd_vld, psh_vld;

  logic [IW-1:0]      rd_addr, wa;
  logic               off_we, st_we, spd_we, psh_we;
  logic signed [31:0] off_wx, off_wy, spd_wx, spd_wy, psh_wx, psh_wy;
  logic signed [31:0] q_ox, q_oy, q_sx, q_sy, q_vx, q_vy, q_px, q_py;

  always_ff @(posedge clk) begin
    if (off_we) begin
      off_x_mem[wa] <= off_wx;
      off_y_mem[wa] <= off_wy;
    end
    if (st_we) begin
      st_x_mem[wa] <= req.value_x;
      st_y_mem[wa] <= req.value_y;
    end
    if (spd_we) begin
      spd_x_mem[wa] <= spd_wx;
      spd_y_mem[wa] <= spd_wy;
    end
    if (psh_we) begin
      psh_x_mem[wa] <= psh_wx;
      psh_y_mem[wa] <= psh_wy;
    end
  end

  // Speed and force entries read as zero until first written.
  always_ff @(posedge clk) begin
    if (rst) begin
      spd_vld <= '0;
      psh_vld <= '0;
    end else begin
      if (spd_we) spd_vld[wa] <= 1'b1;
      if (psh_we) psh_vld[wa] <= 1'b1;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    q_ox <= off_x_mem[rd_addr];
    q_oy <= off_y_mem[rd_addr];
    q_sx <= st_x_mem[rd_addr];
    q_sy <= st_y_mem[rd_addr];
    q_vx <= spd_vld[rd_addr] ? spd_x_mem[rd_addr] : 32'sd0;
    q_vy <= spd_vld[rd_addr] ? spd_y_mem[rd_addr] : 32'sd0;
    q_px <= psh_vld[rd_addr] ? psh_x_mem[rd_addr] : 32'sd0;
    q_py <= psh_vld[rd_addr] ? psh_y_mem[rd_addr] : 32'sd0;
  end

  // Datapath registers.
  logic signed [31:0] body_x, body_y;
  logic signed [31:0] opx, opy, spx, spy, ppx, ppy, pcx, pcy;
  logic signed [31:0] tx, qdx, wx, wy;
  logic signed [33:0] dy_q;
  logic signed [51:0] mul_q;
  logic signed [SW-1:0] sum_x, sum_y;

  // Shared multiplier: spring stretch times tension.
  logic signed [33:0] dx_c, dy_c, mul_a;
  logic signed [17:0] ten_s;
  logic signed [51:0] mul_p;
  logic signed [31:0] ty;
  assign dx_c  = (34'(q_ox) - 34'(opx)) - (34'(q_sx) - 34'(spx));
  assign dy_c  = (34'(q_oy) - 34'(opy)) - (34'(q_sy) - 34'(spy));
  assign ten_s = $signed({1'b0, tension});
  assign mul_a = (state == mssb_pkg::S_C_LD) ? dx_c : dy_q;
  assign mul_p = 52'(mul_a) * 52'(ten_s);
  assign ty    = mssb_pkg::sat32(64'(mul_q >>> 16));

  // Shared divider.
  logic                 div_go;
  logic signed [SW-1:0] div_a;
  logic [10:0]          div_b;
  logic signed [SW-1:0] div_q;
  mssb_pkg::div_stat_t  div_st;

  mssb_div #(.DW(SW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .stat     (div_st)
  );

  // Cell move results.
  logic signed [31:0] qdy, spd_nx, spd_ny, off_nx, off_ny;
  assign qdy    = div_q[31:0];
  assign spd_nx = mssb_pkg::sat32(64'(q_vx >>> 1) + 64'(qdx));
  assign spd_ny = mssb_pkg::sat32(64'(q_vy >>> 1) + 64'(qdy));
  assign off_nx = mssb_pkg::sat32(64'(q_ox) + 64'(spd_nx));
  assign off_ny = mssb_pkg::sat32(64'(q_oy) + 64'(spd_ny));

  logic out_load;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= mssb_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Sequencer: next state, store writes and divider requests.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_addr    = ca;
    wa         = ca;
    off_we     = 1'b0;
    st_we      = 1'b0;
    spd_we     = 1'b0;
    psh_we     = 1'b0;
    off_wx     = req.value_x;
    off_wy     = req.value_y;
    spd_wx     = 32'sd0;
    spd_wy     = 32'sd0;
    psh_wx     = 32'sd0;
    psh_wy     = 32'sd0;
    div_go     = 1'b0;
    div_a      = SW'(q_px);
    div_b      = mass_div;
    out_load   = 1'b0;
    unique case (state)
      mssb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = mssb_pkg::S_DISPATCH;
      end
      mssb_pkg::S_DISPATCH: begin
        rd_addr    = idx_a;
        wa         = idx_a;
        state_next = mssb_pkg::S_DONE;
        unique case (req.command)
          mssb_pkg::CMD_LOAD: begin
            if (in_range) begin
              off_we = 1'b1;
              st_we  = 1'b1;
              spd_we = 1'b1;
              psh_we = 1'b1;
            end
          end
          mssb_pkg::CMD_FORCE, mssb_pkg::CMD_READ: begin
            if (in_range) state_next = mssb_pkg::S_CMD_LD;
          end
          mssb_pkg::CMD_STEP: begin
            state_next = (n == '0) ? mssb_pkg::S_WRAP : mssb_pkg::S_P_RD;
          end
          default: ;
        endcase
      end
      mssb_pkg::S_CMD_LD: begin
        wa = idx_a;
        if (req.command == mssb_pkg::CMD_FORCE) begin
          psh_we = 1'b1;
          psh_wx = mssb_pkg::sat32(64'(q_px) + 64'(req.value_x));
          psh_wy = mssb_pkg::sat32(64'(q_py) + 64'(req.value_y));
        end
        state_next = mssb_pkg::S_DONE;
      end
      mssb_pkg::S_P_RD: begin
        rd_addr    = pa;
        state_next = mssb_pkg::S_P_LD;
      end
      mssb_pkg::S_P_LD: state_next = mssb_pkg::S_C_RD;
      mssb_pkg::S_C_RD: begin
        priority if (c == n) state_next = mssb_pkg::S_P_WB;
        else if (c == p)     state_next = mssb_pkg::S_C_RD;
        else                 state_next = mssb_pkg::S_C_LD;
      end
      mssb_pkg::S_C_LD: state_next = mssb_pkg::S_MULY;
      mssb_pkg::S_MULY: state_next = mssb_pkg::S_ACC;
      mssb_pkg::S_ACC: begin
        psh_we     = 1'b1;
        psh_wx     = mssb_pkg::sat32(64'(pcx) - 64'(tx));
        psh_wy     = mssb_pkg::sat32(64'(pcy) - 64'(ty));
        state_next = mssb_pkg::S_C_RD;
      end
      mssb_pkg::S_P_WB: begin
        wa         = pa;
        psh_we     = 1'b1;
        psh_wx     = ppx;
        psh_wy     = ppy;
        state_next = (p_inc == n) ? mssb_pkg::S_M_RD : mssb_pkg::S_P_RD;
      end
      mssb_pkg::S_M_RD: state_next = mssb_pkg::S_M_LD;
      mssb_pkg::S_M_LD: begin
        div_go     = 1'b1;
        state_next = mssb_pkg::S_DIV_X;
      end
      mssb_pkg::S_DIV_X: begin
        div_a = SW'(q_py);
        if (div_st.done) begin
          div_go     = 1'b1;
          state_next = mssb_pkg::S_DIV_Y;
        end
      end
      mssb_pkg::S_DIV_Y: begin
        if (div_st.done) state_next = mssb_pkg::S_M_WB;
      end
      mssb_pkg::S_M_WB: begin
        off_we     = 1'b1;
        off_wx     = off_nx;
        off_wy     = off_ny;
        spd_we     = 1'b1;
        spd_wx     = spd_nx;
        spd_wy     = spd_ny;
        psh_we     = 1'b1;
        state_next = (c_inc == n) ? mssb_pkg::S_MEAN_GO : mssb_pkg::S_M_RD;
      end
      mssb_pkg::S_MEAN_GO: begin
        div_go     = 1'b1;
        div_a      = sum_x;
        div_b      = 11'(n);
        state_next = mssb_pkg::S_MEAN_X;
      end
      mssb_pkg::S_MEAN_X: begin
        div_a = sum_y;
        div_b = 11'(n);
        if (div_st.done) begin
          div_go     = 1'b1;
          state_next = mssb_pkg::S_MEAN_Y;
        end
      end
      mssb_pkg::S_MEAN_Y: begin
        if (div_st.done) state_next = mssb_pkg::S_WRAP;
      end
      mssb_pkg::S_WRAP: state_next = mssb_pkg::S_DONE;
      mssb_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = mssb_pkg::S_IDLE;
        end
      end
      default: state_next = mssb_pkg::S_IDLE;
    endcase
  end

  // Body position needs a reset value; the rest of the datapath does not.
  always_ff @(posedge clk) begin
    if (rst) begin
      body_x <= 32'sd0;
      body_y <= 32'sd0;
    end else if (state == mssb_pkg::S_DISPATCH && req.command == mssb_pkg::CMD_SETPOS) begin
      body_x <= req.value_x;
      body_y <= req.value_y;
    end else if (state == mssb_pkg::S_WRAP) begin
      body_x <= mssb_pkg::wrap32(wx, screen_width);
      body_y <= mssb_pkg::wrap32(wy, screen_height);
    end
  end

  // Datapath updates per sequencer state.
  always_ff @(posedge clk) begin
    unique case (state)
      mssb_pkg::S_IDLE: begin
        if (in_valid) req <= in_data;
      end
      mssb_pkg::S_DISPATCH: begin
        p  <= '0;
        wx <= body_x;
        wy <= body_y;
        // A load echoes its offset; a cell address out of range only sets status.
        unique case (req.command)
          mssb_pkg::CMD_LOAD: begin
            if (in_range) res <= '{result_x: req.value_x, result_y: req.value_y, status: 1'b0};
            else          res <= '{result_x: 32'sd0, result_y: 32'sd0, status: 1'b1};
          end
          mssb_pkg::CMD_FORCE, mssb_pkg::CMD_READ: begin
            res <= '{result_x: 32'sd0, result_y: 32'sd0, status: !in_range};
          end
          default: res <= '0;
        endcase
      end
      mssb_pkg::S_CMD_LD: begin
        if (req.command == mssb_pkg::CMD_READ) begin
          res.result_x <= q_ox;
          res.result_y <= q_oy;
        end
      end
      mssb_pkg::S_P_LD: begin
        opx <= q_ox;
        opy <= q_oy;
        spx <= q_sx;
        spy <= q_sy;
        ppx <= q_px;
        ppy <= q_py;
        c   <= '0;
      end
      mssb_pkg::S_C_RD: begin
        if (c != n && c == p) c <= c_inc;
      end
      mssb_pkg::S_C_LD: begin
        dy_q  <= dy_c;
        pcx   <= q_px;
        pcy   <= q_py;
        mul_q <= mul_p;
      end
      mssb_pkg::S_MULY: begin
        tx    <= mssb_pkg::sat32(64'(mul_q >>> 16));
        mul_q <= mul_p;
      end
      mssb_pkg::S_ACC: begin
        ppx <= mssb_pkg::sat32(64'(ppx) + 64'(tx));
        ppy <= mssb_pkg::sat32(64'(ppy) + 64'(ty));
        c   <= c_inc;
      end
      mssb_pkg::S_P_WB: begin
        p     <= p_inc;
        c     <= '0;
        sum_x <= '0;
        sum_y <= '0;
      end
      mssb_pkg::S_DIV_X: begin
        if (div_st.done) qdx <= div_q[31:0];
      end
      mssb_pkg::S_M_WB: begin
        sum_x <= sum_x + SW'(mssb_pkg::sat32(64'(q_ox) + 64'(body_x)));
        sum_y <= sum_y + SW'(mssb_pkg::sat32(64'(q_oy) + 64'(body_y)));
        c     <= c_inc;
      end
      mssb_pkg::S_MEAN_X: begin
        if (div_st.done) wx <= mssb_pkg::sat32(64'(div_q));
      end
      mssb_pkg::S_MEAN_Y: begin
        if (div_st.done) wy <= mssb_pkg::sat32(64'(div_q));
      end
      mssb_pkg::S_WRAP: begin
        res <= '{result_x: mssb_pkg::wrap32(wx, screen_width),
                 result_y: mssb_pkg::wrap32(wy, screen_height),
                 status:   1'b0};
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= res;
  end

`ifndef SYNTHESIS
  // The divider is only started when it is free.
  assert property (@(posedge clk) disable iff (rst) div_go |-> !div_st.busy)
    else $error("divider started while busy");

  // An accepted request is decoded in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == mssb_pkg::S_DISPATCH))
    else $error("accepted request not dispatched");

  // A finished request always lands in the output register.
  assert property (@(posedge clk) disable iff (rst)
    (state == mssb_pkg::S_DONE && (!out_valid || out_ready)) |=> out_valid)
    else $error("response lost");
`endif

endmodule

// ===== tb/sv/mass_spring_soft_body_step_top_tb.sv =====
// ----------------------------------------------------------------------------
// Mass-spring soft body step testbench
// Drives load, force, position, step, read and unused command requests through the
// valid and ready handshake, predicts every response with an independent
// fixed-point model of the body and compares each field. It runs several register
// settings, including the extremes, with random stalls on both sides in most phases.
// ----------------------------------------------------------------------------
module mass_spring_soft_body_step_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = 16;

  // Command codes the block leaves unused.
  localparam mssb_pkg::cmd_t CMD_SPARE_LO = 3'd5;
  localparam mssb_pkg::cmd_t CMD_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mssb_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mssb_pkg::rsp_t out_data;
  logic cfg_we = 1'b0;
  mssb_pkg::reg_idx_t cfg_index = mssb_pkg::REG_TENSION;
  logic [mssb_pkg::CFG_W-1:0] cfg_data = '0;

  mass_spring_soft_body_step_top #(.MAX_CELLS(CELLS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Requests waiting to be driven and responses the body model predicts.
  mssb_pkg::req_t pending_reqs[$];
  mssb_pkg::rsp_t predicted_rsps[$];
  int errors = 0;
  int idle_mode = 0;

  // Shadow registers and cell state of the body model.
  logic [16:0] sh_tension = mssb_pkg::TENSION_RST;
  logic [10:0] sh_mass = mssb_pkg::MASS_RST;
  logic [4:0]  sh_count = mssb_pkg::COUNT_RST;
  logic [15:0] sh_width = mssb_pkg::WIDTH_RST;
  logic [15:0] sh_height = mssb_pkg::HEIGHT_RST;
  logic signed [31:0] pos_x[CELLS], pos_y[CELLS], rest_x[CELLS], rest_y[CELLS];
  logic signed [31:0] vel_x[CELLS], vel_y[CELLS], frc_x[CELLS], frc_y[CELLS];
  logic signed [31:0] body_px = 0, body_py = 0;

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      pos_x[i] = 0; pos_y[i] = 0; rest_x[i] = 0; rest_y[i] = 0;
      vel_x[i] = 0; vel_y[i] = 0; frc_x[i] = 0; frc_y[i] = 0;
    end
  end

  // Append a request to the queue of pending requests.
  task automatic queue_req(input mssb_pkg::req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] screen_wrap(logic signed [31:0] p,
                                                     logic [15:0] lim);
    longint w;
    longint x;
    w = longint'(lim) * 65536;
    x = p;
    if (x > w) x = x - w;
    if (x < 0) x = x + w;
    return clamp32(x);
  endfunction

  // Spring force on one axis between a parent and a child cell.
  function automatic longint spring_pull(logic signed [31:0] oc, logic signed [31:0] op,
                                         logic signed [31:0] sc, logic signed [31:0] sp);
    longint d;
    d = (longint'(oc) - longint'(op)) - (longint'(sc) - longint'(sp));
    return longint'(clamp32((d * longint'(sh_tension)) >>> 16));
  endfunction

  // Semi-implicit Euler step of the whole body.
  task automatic integrate_body();
    int n;
    longint m;
    longint sum_x;
    longint sum_y;
    longint t;
    n = (sh_count < CELLS) ? int'(sh_count) : CELLS;
    m = (sh_mass != 0) ? longint'(sh_mass) : 1;
    sum_x = 0;
    sum_y = 0;
    if (n == 0) begin
      body_px = screen_wrap(body_px, sh_width);
      body_py = screen_wrap(body_py, sh_height);
      return;
    end
    for (int p = 0; p < n; p++) begin
      for (int c = 0; c < n; c++) begin
        if (p != c) begin
          t = spring_pull(pos_x[c], pos_x[p], rest_x[c], rest_x[p]);
          frc_x[c] = clamp32(longint'(frc_x[c]) - t);
          frc_x[p] = clamp32(longint'(frc_x[p]) + t);
          t = spring_pull(pos_y[c], pos_y[p], rest_y[c], rest_y[p]);
          frc_y[c] = clamp32(longint'(frc_y[c]) - t);
          frc_y[p] = clamp32(longint'(frc_y[p]) + t);
        end
      end
    end
    for (int c = 0; c < n; c++) begin
      sum_x += longint'(clamp32(longint'(pos_x[c]) + longint'(body_px)));
      sum_y += longint'(clamp32(longint'(pos_y[c]) + longint'(body_py)));
      vel_x[c] = clamp32(longint'(vel_x[c] >>> 1) + longint'(frc_x[c]) / m);
      vel_y[c] = clamp32(longint'(vel_y[c] >>> 1) + longint'(frc_y[c]) / m);
      pos_x[c] = clamp32(longint'(pos_x[c]) + longint'(vel_x[c]));
      pos_y[c] = clamp32(longint'(pos_y[c]) + longint'(vel_y[c]));
      frc_x[c] = 0;
      frc_y[c] = 0;
    end
    body_px = screen_wrap(clamp32(sum_x / n), sh_width);
    body_py = screen_wrap(clamp32(sum_y / n), sh_height);
  endtask

  // Apply one request to the body model and return the response it causes.
  task automatic apply_request(input mssb_pkg::req_t r, output mssb_pkg::rsp_t e);
    int n;
    int idx;
    n = (sh_count < CELLS) ? int'(sh_count) : CELLS;
    idx = int'(r.cell_index);
    e = '0;
    case (r.command)
      mssb_pkg::CMD_LOAD, mssb_pkg::CMD_FORCE, mssb_pkg::CMD_READ: begin
        if (idx >= n) begin
          e.status = 1'b1;
        end else if (r.command == mssb_pkg::CMD_LOAD) begin
          pos_x[idx] = r.value_x; pos_y[idx] = r.value_y;
          rest_x[idx] = r.value_x; rest_y[idx] = r.value_y;
          vel_x[idx] = 0; vel_y[idx] = 0; frc_x[idx] = 0; frc_y[idx] = 0;
          e.result_x = r.value_x; e.result_y = r.value_y;
        end else if (r.command == mssb_pkg::CMD_FORCE) begin
          frc_x[idx] = clamp32(longint'(frc_x[idx]) + longint'(r.value_x));
          frc_y[idx] = clamp32(longint'(frc_y[idx]) + longint'(r.value_y));
        end else begin
          e.result_x = pos_x[idx]; e.result_y = pos_y[idx];
        end
      end
      mssb_pkg::CMD_SETPOS: begin
        body_px = r.value_x; body_py = r.value_y;
      end
      mssb_pkg::CMD_STEP: begin
        integrate_body();
        e.result_x = body_px; e.result_y = body_py;
      end
      default: ;
    endcase
  endtask

  // Driver: present queued requests, with random gaps, and predict on accept.
  always @(posedge clk) begin
    logic take;
    logic gap;
    mssb_pkg::rsp_t e;
    if (!rst) begin
      take = in_valid && in_ready;
      if (take) begin
        apply_request(in_data, e);
        predicted_rsps = {predicted_rsps, e};
      end
      if (!in_valid || take) begin
        gap = (idle_mode == 0) ? ($urandom_range(99) < 26) :
              (idle_mode == 1) ? ($urandom_range(99) < 49) : 1'b0;
        if (pending_reqs.size() != 0 && !gap) begin
          in_valid <= 1'b1;
          in_data <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and field checks against the prediction.
  always @(posedge clk) begin
    mssb_pkg::rsp_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (predicted_rsps.size() == 0) begin
          $error("response with no request outstanding");
          errors++;
        end else begin
          e = predicted_rsps.pop_front();
          if (out_data.result_x !== e.result_x) begin
            $error("result_x expected %h actual %h", e.result_x, out_data.result_x);
            errors++;
          end
          if (out_data.result_y !== e.result_y) begin
            $error("result_y expected %h actual %h", e.result_y, out_data.result_y);
            errors++;
          end
          if (out_data.status !== e.status) begin
            $error("status expected %b actual %b", e.status, out_data.status);
            errors++;
          end
        end
      end
      out_ready <= (idle_mode == 0) ? ($urandom_range(99) >= 49) :
                   (idle_mode == 1) ? ($urandom_range(99) >= 26) : 1'b1;
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $signed($urandom);
      1: return $signed($urandom_range(32'h01ff_ffff)) - 32'sh0100_0000;
      default: return $signed($urandom_range(32'h000f_ffff)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic mssb_pkg::req_t rand_request();
    mssb_pkg::req_t r;
    int pick;
    pick = $urandom_range(99);
    r.command = (pick < 20) ? mssb_pkg::CMD_LOAD : (pick < 45) ? mssb_pkg::CMD_FORCE :
                (pick < 55) ? mssb_pkg::CMD_SETPOS : (pick < 73) ? mssb_pkg::CMD_STEP :
                (pick < 95) ? mssb_pkg::CMD_READ :
                mssb_pkg::cmd_t'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    r.cell_index = 4'($urandom_range(15));
    r.value_x = rand_coord();
    r.value_y = rand_coord();
    return r;
  endfunction

  function automatic mssb_pkg::req_t make_req(mssb_pkg::cmd_t c, int idx, logic [31:0] x,
                                              logic [31:0] y);
    mssb_pkg::req_t r;
    r.command = c;
    r.cell_index = idx[3:0];
    r.value_x = x;
    r.value_y = y;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || predicted_rsps.size() != 0)
      @(posedge clk);
  endtask

  // One register write, taken at the next rising edge.
  task automatic cfg_write(input mssb_pkg::reg_idx_t idx,
                           input logic [mssb_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Registers change only while the block is idle.
  task automatic write_regs(logic [16:0] ten, logic [10:0] mass, logic [4:0] cnt,
                            logic [15:0] w, logic [15:0] h);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_write(mssb_pkg::REG_TENSION, ten);
    cfg_write(mssb_pkg::REG_MASS, 17'(mass));
    cfg_write(mssb_pkg::REG_COUNT, 17'(cnt));
    cfg_write(mssb_pkg::REG_WIDTH, 17'(w));
    cfg_write(mssb_pkg::REG_HEIGHT, 17'(h));
    cfg_we <= 1'b0;
    sh_tension = ten; sh_mass = mass; sh_count = cnt; sh_width = w; sh_height = h;
  endtask

  task automatic random_phase(int mode, int items, logic [16:0] ten, logic [10:0] mass,
                              logic [4:0] cnt, logic [15:0] w, logic [15:0] h);
    write_regs(ten, mass, cnt, w, h);
    idle_mode = mode;
    for (int i = 0; i < items; i++) queue_req(rand_request());
  endtask

  // Stimulus: directed corners first, then random phases over many settings.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_regs(mssb_pkg::TENSION_RST, mssb_pkg::MASS_RST, 5'd16, mssb_pkg::WIDTH_RST,
               mssb_pkg::HEIGHT_RST);
    idle_mode = 0;
    // Every cell gets loaded so that no step or read touches an unwritten cell.
    queue_req(make_req(mssb_pkg::CMD_LOAD, 0, 32'h8000_0000, 32'h7fff_ffff));
    queue_req(make_req(mssb_pkg::CMD_LOAD, 1, 32'h7fff_ffff, 32'h8000_0000));
    for (int i = 2; i < CELLS; i++)
      queue_req(make_req(mssb_pkg::CMD_LOAD, i, rand_coord(), rand_coord()));
    queue_req(make_req(mssb_pkg::CMD_READ, 0, 0, 0));
    queue_req(make_req(mssb_pkg::CMD_FORCE, 2, 32'h7fff_ffff, 32'h8000_0000));
    queue_req(make_req(mssb_pkg::CMD_FORCE, 2, 32'h7fff_ffff, 32'h8000_0000));
    queue_req(make_req(mssb_pkg::CMD_SETPOS, 0, 32'h7fff_ffff, 32'h8000_0000));
    queue_req(make_req(mssb_pkg::CMD_STEP, 0, 0, 0));
    queue_req(make_req(mssb_pkg::CMD_READ, 15, 0, 0));
    queue_req(make_req(CMD_SPARE_LO, 3, 32'hffff_ffff, 32'hffff_ffff));
    queue_req(make_req(CMD_SPARE_HI, 15, 32'h1234_5678, 32'h8765_4321));
    // Sender holds off until the block has drained completely.
    wait_drained();
    repeat (20) @(posedge clk);
    queue_req(make_req(mssb_pkg::CMD_SETPOS, 0, 32'h8000_0000, 32'h0000_0000));
    queue_req(make_req(mssb_pkg::CMD_STEP, 0, 0, 0));
    random_phase(0, 400, 17'd6554, 11'd10, 5'd4, 16'd640, 16'd480);
    random_phase(0, 200, 17'd0, 11'd1, 5'd1, 16'd1, 16'd65535);
    random_phase(1, 60, 17'd65536, 11'd1024, 5'd16, 16'd65535, 16'd1);
    random_phase(1, 40, 17'd131071, 11'd0, 5'd31, 16'd320, 16'd200);
    random_phase(1, 100, 17'd1000, 11'd3, 5'd0, 16'd100, 16'd100);
    random_phase(2, 500, 17'd30000, 11'd2047, 5'd2, 16'd800, 16'd600);
    random_phase(2, 500, 17'd6554, 11'd7, 5'd3, 16'd1024, 16'd768);
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mssb_pkg.sv
hdl/mssb_div.sv
hdl/mass_spring_soft_body_step_top.sv
tb/sv/mass_spring_soft_body_step_top_tb.sv
